@@ src/blstk_pkg.sv @@
// types and codes shared by the bounded lifo stack and its testbench
// no dependencies
package blstk_pkg;

   localparam int WORD_WIDTH = 32;

   // command codes; codes above CMD_EMPTY are invalid
   typedef enum logic [2:0] {
      CMD_PUSH  = 3'd0,
      CMD_POP   = 3'd1,
      CMD_TOP   = 3'd2,
      CMD_DUMP  = 3'd3,
      CMD_EMPTY = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_BUSY = 1'b1
   } state_type;

   typedef struct packed {
      logic [2:0]                    cmd;
      logic signed [WORD_WIDTH-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0]  value;
      logic                          has_value;
      logic [1:0]                    status;
      logic                          last;
   } rsp_type;

endpackage

@@ src/blstk_ram.sv @@
// generic single-write, single-read ram with a registered read port
// no dependencies
module blstk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bounded_lifo_stack.sv @@
// bounded lifo stack of signed words, entries held in one blstk_ram
// depends on blstk_pkg and blstk_ram
//
//   channel  ports                          direction  payload
//   request  req_valid req_stall req_data   in         blstk_pkg::req_type
//   response rsp_valid rsp_stall rsp_data   out        blstk_pkg::rsp_type
//
// push, is-empty, invalid and error cases: answered straight from the request
// pop and top: ram read is registered, then the entry moves to the output register
// dump: one ram read per entry, overlapped with output
// reset clears the fill count and control state; ram contents stay undefined
// a stalled response holds the output register; dump reads pause behind it
module bounded_lifo_stack #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  blstk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output blstk_pkg::rsp_type rsp_data
);
   import blstk_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic                  out_free;
   logic                  accept;
   logic                  load;
   logic                  wr_en;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [WORD_WIDTH-1:0] rd_data;
   logic [CW-1:0]         fill_dec;
   logic [CW-1:0]         iss_inc;

   blstk_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_data.push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign fill_dec  = fill_ff - CW'(1);
   assign iss_inc   = iss_ff + CW'(1);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      iss_in       = iss_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      load         = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = iss_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load   = 1'b1;
               rsp_in = '{value: '0, has_value: 1'b0, status: ST_OK, last: 1'b1};
               unique case (req_data.cmd) inside
                  CMD_PUSH: begin
                     if (fill_ff == CW'(DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  CMD_POP, CMD_TOP: begin
                     if (fill_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        // response comes out of the ram next cycle
                        load         = 1'b0;
                        rd_en        = 1'b1;
                        rd_addr      = fill_dec[AW-1:0];
                        pend_in      = 1'b1;
                        pend_last_in = 1'b1;
                        // read index parks at the new fill count, no dump read follows
                        iss_in       = fill_ff;
                        state_in     = S_BUSY;
                        if (req_data.cmd == CMD_POP) begin
                           fill_in = fill_dec;
                           iss_in  = fill_dec;
                        end
                     end
                  end
                  CMD_DUMP: begin
                     if (fill_ff != '0) begin
                        load         = 1'b0;
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        pend_in      = 1'b1;
                        pend_last_in = (fill_ff == CW'(1));
                        iss_in       = CW'(1);
                        state_in     = S_BUSY;
                     end
                  end
                  CMD_EMPTY: begin
                     rsp_in.value     = {{(WORD_WIDTH-1){1'b0}}, (fill_ff == '0)};
                     rsp_in.has_value = 1'b1;
                  end
                  default: begin
                     rsp_in.status = ST_INVALID;
                  end
               endcase
            end
         end
         S_BUSY: begin
            // ram data for the pending entry moves to the output register
            if (pend_ff && out_free) begin
               load   = 1'b1;
               rsp_in = '{value: rd_data, has_value: 1'b1, status: ST_OK,
                          last: pend_last_ff};
               pend_in = 1'b0;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end
            end
            // next dump read once the ram output is free to be overwritten
            if ((iss_ff != fill_ff) && (!pend_ff || out_free)) begin
               rd_en        = 1'b1;
               rd_addr      = iss_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_last_in = (iss_inc == fill_ff);
               iss_in       = iss_inc;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY) |-> req_stall)
      else $error("request taken while busy");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_BUSY))
      else $error("ram read pending outside busy");

   a_fill_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY) |=> $stable(fill_ff))
      else $error("fill count changed during read-out");

   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (state_ff == S_BUSY))
      else $error("non-final response outside dump");
`endif

endmodule

@@ tb/bounded_lifo_stack_test.sv @@
// testbench for bounded_lifo_stack: directed and random command traffic with a stack model
// and a response checker; depends on blstk_pkg and bounded_lifo_stack
`timescale 1ns / 100ps

module bounded_lifo_stack_test;
   import blstk_pkg::*;

   localparam int STACK_DEPTH = 64;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam logic [2:0] LAST_CMD_CODE = '1;
   localparam logic [2:0] FIRST_BAD_CMD = 3'(CMD_EMPTY) + 3'd1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // model of the stack contents and the responses still to come
   logic signed [WORD_WIDTH-1:0] stack_words [STACK_DEPTH];
   int unsigned                  word_count = 0;
   rsp_type                      pending_rsps [$];

   int error_count = 0;
   int cycle_count = 0;
   bit request_gaps = 1'b1;
   bit random_stalls = 1'b1;
   int hold_request = 0;
   int hold_left = 0;
   int stall_left = 0;

   bounded_lifo_stack #(.DEPTH(STACK_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 11))
         0: return {1'b1, {(WORD_WIDTH-1){1'b0}}};
         1: return {1'b0, {(WORD_WIDTH-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic void queue_stack_results(input req_type r);
      rsp_type o;
      int      k;
      o = '0;
      o.last = 1'b1;
      o.status = ST_OK;
      case (r.cmd)
         CMD_PUSH: begin
            if (word_count < STACK_DEPTH) begin
               stack_words[word_count] = r.push_value;
               word_count++;
            end else begin
               o.status = ST_FULL;
            end
         end
         CMD_POP, CMD_TOP: begin
            if (word_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.value = stack_words[word_count-1];
               o.has_value = 1'b1;
               if (r.cmd == CMD_POP)
                  word_count--;
            end
         end
         CMD_DUMP: begin
            // bottom to top, last marks the top entry
            for (k = 0; k < int'(word_count); k++) begin
               o.value = stack_words[k];
               o.has_value = 1'b1;
               o.last = (k + 1 == int'(word_count));
               pending_rsps.push_back(o);
            end
            if (word_count != 0)
               return;
         end
         CMD_EMPTY: begin
            o.has_value = 1'b1;
            o.value = (word_count == 0) ? 1 : 0;
         end
         default: o.status = ST_INVALID;
      endcase
      pending_rsps.push_back(o);
   endfunction

   // one process sees both channels so prediction always precedes the check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            queue_stack_results(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
               $error("unexpected response transaction: value %0d status %0d",
                      rsp_data.value, rsp_data.status);
               error_count++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_data.value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_data.value);
                  error_count++;
               end
               if (rsp_data.has_value !== want.has_value) begin
                  $error("has_value: expected %0b, got %0b", want.has_value,
                         rsp_data.has_value);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (random_stalls && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(input logic [2:0] cmd, input logic signed [WORD_WIDTH-1:0] word);
      int gap;
      gap = request_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: cmd, push_value: word};
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic pause_requests();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_results();
      while (pending_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_stack();
      send_request(CMD_POP, pick_word());
      send_request(CMD_TOP, pick_word());
      send_request(CMD_DUMP, pick_word());
      send_request(CMD_EMPTY, pick_word());
      for (int c = FIRST_BAD_CMD; c <= LAST_CMD_CODE; c++)
         send_request(3'(c), pick_word());
   endtask

   task automatic test_word_extremes();
      send_request(CMD_PUSH, {1'b1, {(WORD_WIDTH-1){1'b0}}});
      send_request(CMD_PUSH, {1'b0, {(WORD_WIDTH-1){1'b1}}});
      send_request(CMD_PUSH, '0);
      send_request(CMD_PUSH, '1);
      send_request(CMD_PUSH, 32'h5555_aaaa);
      send_request(CMD_TOP, '1);
      send_request(CMD_EMPTY, '0);
      send_request(CMD_DUMP, '0);
      send_request(LAST_CMD_CODE, '1);
      repeat (6) send_request(CMD_POP, pick_word());
      send_request(CMD_EMPTY, '1);
   endtask

   // receiver holds off while the sender keeps pushing, so the input stalls; the stack fills up and
   // full, dump and invalid commands then run against a full stack
   task automatic test_full_backpressure();
      pause_requests();
      wait_for_results();
      request_gaps = 1'b0;
      hold_request = 400;
      repeat (STACK_DEPTH) send_request(CMD_PUSH, pick_word());
      send_request(CMD_PUSH, pick_word());
      send_request(CMD_EMPTY, pick_word());
      send_request(CMD_DUMP, pick_word());
      send_request(CMD_TOP, pick_word());
      send_request(FIRST_BAD_CMD, pick_word());
      request_gaps = 1'b1;
      repeat (STACK_DEPTH) send_request(CMD_POP, pick_word());
      send_request(CMD_POP, pick_word());
   endtask

   // alternating fill and drain phases move the stack up and down
   task automatic test_random_traffic(input int count);
      int         n;
      int         pick;
      bit         filling;
      logic [2:0] cmd;
      filling = 1'b0;
      for (n = 0; n < count; n++) begin
         if (n % 12 == 0)
            filling = ~filling;
         request_gaps = (n % 20) < 15;
         random_stalls = (n % 25) < 18;
         pick = $urandom_range(0, 99);
         if (pick < (filling ? 55 : 15))
            cmd = CMD_PUSH;
         else if (pick < 70)
            cmd = CMD_POP;
         else if (pick < 78)
            cmd = CMD_TOP;
         else if (pick < 83)
            cmd = CMD_DUMP;
         else if (pick < 91)
            cmd = CMD_EMPTY;
         else
            cmd = 3'($urandom_range(FIRST_BAD_CMD, LAST_CMD_CODE));
         send_request(cmd, pick_word());
      end
      request_gaps = 1'b1;
      random_stalls = 1'b1;
   endtask

   task automatic test_sender_pause();
      pause_requests();
      wait_for_results();
      send_request(CMD_DUMP, pick_word());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_stack();
      test_word_extremes();
      test_full_backpressure();
      test_random_traffic(31);
      test_sender_pause();
      test_random_traffic(31);
      pause_requests();
      wait_for_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
